// ===== rtl/core/pisd_pkg.sv =====
// shared constants and result codes for the palette image stream decoder
package pisd_pkg;

	localparam int PAL_DEPTH_DEF = 256;
	localparam int PAL_DEPTH_MAX = 256;

	// result status codes
	localparam logic [1:0] ST_PIXEL = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

endpackage

// ===== rtl/core/pisd_ram.sv =====
// generic single write port, single read port ram with registered read data
module pisd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/palette_image_stream_decoder_core.sv =====
// palette image stream decoder: header check, palette load and index to pixel mapping
//
// input channel: one blob byte per request (in_byte, end_of_blob marks the
//   last byte), valid/stall handshake, taken when in_valid is high and
//   in_stall is low
// output channel: one result per request (pixel_word, col, line, status,
//   final_res); a pixel result carries status 0, the closing status result
//   of a blob carries final_res 1 and zero pixel fields
// order: a pixel request passes the first stage, where the palette ram is
//   read, and then the output register before it is offered; header
//   and palette bytes give no pixel result
// throughput: one byte per cycle unless the output stalls; a byte giving
//   a pixel and the closing status gives two results, stalling the input
//   until the pixel has left; the palette ram read port sets the two stage depth
// stall: out_stall holds the output register; one more request can be
//   taken into the first stage before in_stall rises
// reset: arst_n clears the handshake and decoder state and returns to the
//   header phase; the palette ram is not cleared, only entries loaded in
//   the current blob ever reach the output
module palette_image_stream_decoder_core import pisd_pkg::*; #(
	parameter int PALETTE_DEPTH = PAL_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_blob,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] pixel_word,
	output logic [15:0] col,
	output logic [15:0] line,
	output logic [1:0]  status,
	output logic        final_res
);

	localparam int AW  = $clog2(PALETTE_DEPTH);
	localparam int PCW = $clog2(PALETTE_DEPTH + 1);

	// decoder phases
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_PAL    = 3'd1;
	localparam logic [2:0] PH_PIX    = 3'd2;
	localparam logic [2:0] PH_TAIL   = 3'd3;
	localparam logic [2:0] PH_BAD    = 3'd4;

	// decoder state
	logic [2:0]     phase_q,    phase_d;
	logic [2:0]     hdr_cnt_q,  hdr_cnt_d;
	logic [15:0]    width_q,    width_d;
	logic [15:0]    height_q,   height_d;
	logic [PCW-1:0] pal_cnt_q,  pal_cnt_d;
	logic [23:0]    asm_q,      asm_d;
	logic [PCW-1:0] pal_fill_q, pal_fill_d;
	logic [1:0]     biw_q,      biw_d;
	logic [15:0]    col_cnt_q,  col_cnt_d;
	logic [15:0]    row_cnt_q,  row_cnt_d;

	// first stage: request with its pending results, ram read in flight
	logic        pix_pend_s1;
	logic        stat_pend_s1;
	logic        oob_s1;
	logic [15:0] col_s1;
	logic [15:0] line_s1;
	logic [1:0]  status_s1;

	// second stage: output register
	logic        valid_s2;
	logic [31:0] word_s2;
	logic [15:0] col_s2;
	logic [15:0] line_s2;
	logic [1:0]  status_s2;
	logic        final_s2;

	// handshake and datapath helpers
	logic        s2_free;
	logic        s1_busy;
	logic        move;
	logic        last_move;
	logic        accept;
	logic        pal_wr;
	logic [31:0] pal_wdata;
	logic [31:0] ram_rdata;
	logic        gen_pix;
	logic        pix_oob;
	logic [1:0]  close_st;
	logic [15:0] hdr_full;
	logic [PCW-1:0] fill_inc;
	logic [16:0] col_inc;
	logic [16:0] row_inc;

	// ---------------------------------------------------------------
	// handshake: unless out_stall holds it, s1 drains one result per cycle into the output register
	// ---------------------------------------------------------------
	assign s2_free   = !valid_s2 || !out_stall;
	assign s1_busy   = pix_pend_s1 || stat_pend_s1;
	assign move      = s2_free && s1_busy;
	assign last_move = move && !(pix_pend_s1 && stat_pend_s1);
	assign in_stall  = s1_busy && !last_move;
	assign accept    = in_valid && !in_stall;

	// ---------------------------------------------------------------
	// next state of the byte decoder
	// ---------------------------------------------------------------
	assign hdr_full = {asm_q[7:0], in_byte};
	assign fill_inc = pal_fill_q + PCW'(1);
	assign col_inc  = {1'b0, col_cnt_q} + 17'd1;
	assign row_inc  = {1'b0, row_cnt_q} + 17'd1;
	assign gen_pix  = (phase_q == PH_PIX);
	assign pix_oob  = !({1'b0, in_byte} < 9'(pal_cnt_q));

	always_comb begin
		phase_d    = phase_q;
		hdr_cnt_d  = hdr_cnt_q;
		width_d    = width_q;
		height_d   = height_q;
		pal_cnt_d  = pal_cnt_q;
		asm_d      = asm_q;
		pal_fill_d = pal_fill_q;
		biw_d      = biw_q;
		col_cnt_d  = col_cnt_q;
		row_cnt_d  = row_cnt_q;
		pal_wr     = 1'b0;
		pal_wdata  = {asm_q, in_byte};
		close_st   = ST_TRUNC;

		unique case (phase_q)
			PH_HEADER: begin
				unique case (hdr_cnt_q)
					3'd0: width_d  = {in_byte, 8'd0};
					3'd1: width_d  = {width_q[15:8], in_byte};
					3'd2: height_d = {in_byte, 8'd0};
					3'd3: height_d = {height_q[15:8], in_byte};
					3'd4: asm_d    = {16'd0, in_byte};
					3'd5: begin
						// zero or oversize palette counts are flagged as zero
						if (hdr_full == 16'd0 || hdr_full > 16'(PALETTE_DEPTH)) begin
							pal_cnt_d = '0;
						end else begin
							pal_cnt_d = hdr_full[PCW-1:0];
						end
						asm_d = '0;
					end
					default: ;
				endcase
				if (hdr_cnt_q == 3'd7) begin
					if (width_q == 16'd0 || height_q == 16'd0 || pal_cnt_q == '0) begin
						phase_d = PH_BAD;
					end else begin
						phase_d    = PH_PAL;
						pal_fill_d = '0;
						biw_d      = '0;
						asm_d      = '0;
					end
				end
				hdr_cnt_d = hdr_cnt_q + 3'd1;
			end
			PH_PAL: begin
				if (biw_q != 2'd3) begin
					asm_d = {asm_q[15:0], in_byte};
					biw_d = biw_q + 2'd1;
				end else begin
					// fourth byte completes a big-endian palette word
					pal_wr     = 1'b1;
					asm_d      = '0;
					biw_d      = '0;
					pal_fill_d = fill_inc;
					if (fill_inc >= pal_cnt_q) begin
						phase_d   = PH_PIX;
						col_cnt_d = '0;
						row_cnt_d = '0;
					end
				end
			end
			PH_PIX: begin
				if (col_inc >= {1'b0, width_q}) begin
					col_cnt_d = '0;
					row_cnt_d = row_inc[15:0];
					if (row_inc >= {1'b0, height_q}) begin
						phase_d = PH_TAIL;
					end
				end else begin
					col_cnt_d = col_inc[15:0];
				end
			end
			default: ;
		endcase

		// closing status follows the phase reached after this byte
		priority if (phase_d == PH_TAIL) begin
			close_st = ST_DONE;
		end else if (phase_d == PH_BAD) begin
			close_st = ST_BAD;
		end else begin
			close_st = ST_TRUNC;
		end

		// end of blob restarts the header parse
		if (end_of_blob) begin
			phase_d    = PH_HEADER;
			hdr_cnt_d  = '0;
			width_d    = '0;
			height_d   = '0;
			pal_cnt_d  = '0;
			asm_d      = '0;
			pal_fill_d = '0;
			biw_d      = '0;
			col_cnt_d  = '0;
			row_cnt_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_cnt_q  <= '0;
			width_q    <= '0;
			height_q   <= '0;
			pal_cnt_q  <= '0;
			asm_q      <= '0;
			pal_fill_q <= '0;
			biw_q      <= '0;
			col_cnt_q  <= '0;
			row_cnt_q  <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			hdr_cnt_q  <= hdr_cnt_d;
			width_q    <= width_d;
			height_q   <= height_d;
			pal_cnt_q  <= pal_cnt_d;
			asm_q      <= asm_d;
			pal_fill_q <= pal_fill_d;
			biw_q      <= biw_d;
			col_cnt_q  <= col_cnt_d;
			row_cnt_q  <= row_cnt_d;
		end
	end

	// ---------------------------------------------------------------
	// palette ram: written while loading, read once per pixel byte
	// ---------------------------------------------------------------
	pisd_ram #(
		.WIDTH (32),
		.DEPTH (PALETTE_DEPTH)
	) u_pal_ram (
		.clk   (clk),
		.we    (accept && pal_wr),
		.waddr (pal_fill_q[AW-1:0]),
		.wdata (pal_wdata),
		.re    (accept && gen_pix),
		.raddr (in_byte[AW-1:0]),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------
	// first stage: control flags, no reset on the payload
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_pend_s1  <= 1'b0;
			stat_pend_s1 <= 1'b0;
		end else if (accept) begin
			pix_pend_s1  <= gen_pix;
			stat_pend_s1 <= end_of_blob;
		end else if (move) begin
			// pixel leaves first, status after it
			if (pix_pend_s1) begin
				pix_pend_s1 <= 1'b0;
			end else begin
				stat_pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			oob_s1    <= pix_oob;
			col_s1    <= col_cnt_q;
			line_s1   <= row_cnt_q;
			status_s1 <= close_st;
		end
	end

	// ---------------------------------------------------------------
	// second stage: output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= move;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			if (pix_pend_s1) begin
				word_s2   <= oob_s1 ? 32'd0 : ram_rdata;
				col_s2    <= col_s1;
				line_s2   <= line_s1;
				status_s2 <= ST_PIXEL;
				final_s2  <= 1'b0;
			end else begin
				word_s2   <= '0;
				col_s2    <= '0;
				line_s2   <= '0;
				status_s2 <= status_s1;
				final_s2  <= 1'b1;
			end
		end
	end

	assign out_valid  = valid_s2;
	assign pixel_word = word_s2;
	assign col        = col_s2;
	assign line       = line_s2;
	assign status     = status_s2;
	assign final_res  = final_s2;

endmodule

// ===== rtl/core/pisd_checker.sv =====
// port level checker for the palette image stream decoder, with its bind
module pisd_checker import pisd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] pixel_word,
	input logic [15:0] col,
	input logic [15:0] line,
	input logic [1:0]  status,
	input logic        final_res
);

	// closing result carries a real status and zero pixel fields
	a_close_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_res |->
			pixel_word == 32'd0 && col == 16'd0 && line == 16'd0 && status != ST_PIXEL)
		else $error("closing result with pixel fields or pixel status");

	// pixel results always carry the pixel status
	a_pixel_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !final_res |-> status == ST_PIXEL)
		else $error("pixel result with non-pixel status");

	// input only stalls while a result is owed, so one is offered next cycle
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> out_valid)
		else $error("input stalled with no result to offer");

	// stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			out_valid && $stable(pixel_word) && $stable(col) && $stable(line) &&
			$stable(status) && $stable(final_res))
		else $error("stalled result changed");

endmodule

bind palette_image_stream_decoder_core pisd_checker u_pisd_checker (.*);

// ===== dv/palette_image_stream_decoder_core_tb.sv =====
// self-checking testbench for the palette image stream decoder core
`timescale 1ns / 100ps

module palette_image_stream_decoder_core_tb;
	import pisd_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_BYTES = 1100;
	localparam int MAX_GAP      = 20;

	// decoder phases of the predictor
	typedef enum logic [2:0] {
		DEC_HEADER,
		DEC_PALETTE,
		DEC_PIXELS,
		DEC_TAIL,
		DEC_BAD_HDR
	} dec_phase_t;

	// shapes of generated blobs
	typedef enum int {
		BLOB_GOOD,
		BLOB_TRUNC_HDR,
		BLOB_TRUNC_PAL,
		BLOB_TRUNC_PIX,
		BLOB_BAD_HDR,
		BLOB_NOISE,
		BLOB_EXTREME
	} blob_kind_t;

	// idling modes, rotated blob by blob
	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic [31:0] pixel_word;
		logic [15:0] col;
		logic [15:0] line;
		logic [1:0]  status;
		logic        final_res;
	} pix_result_t;

	// tracks the decoder state and the queue of results still owed
	class pixel_scoreboard;
		pix_result_t expected_results[$];
		int          fail_count;
		dec_phase_t  dec_phase;
		logic [2:0]  hdr_count;
		logic [15:0] img_w;
		logic [15:0] img_h;
		logic [8:0]  pal_cnt;
		logic [31:0] palette[PAL_DEPTH_MAX];
		logic [23:0] assembly;
		logic [8:0]  fill;
		logic [1:0]  byte_idx;
		logic [15:0] col_n;
		logic [15:0] row_n;

		function new();
			foreach (palette[i])
				palette[i] = 32'h0;
			fail_count = 0;
			restart_blob();
		endfunction

		function void restart_blob();
			dec_phase = DEC_HEADER;
			hdr_count = 3'd0;
			img_w     = 16'd0;
			img_h     = 16'd0;
			pal_cnt   = 9'd0;
			assembly  = 24'd0;
			fill      = 9'd0;
			byte_idx  = 2'd0;
			col_n     = 16'd0;
			row_n     = 16'd0;
		endfunction

		// advance the decoder by one accepted byte and queue what it yields
		function void note_byte(logic [7:0] b, logic last);
			pix_result_t r;
			logic [15:0] pal_full;
			case (dec_phase)
			DEC_HEADER: begin
				case (hdr_count)
				3'd0: img_w = {b, 8'h00};
				3'd1: img_w[7:0] = b;
				3'd2: img_h = {b, 8'h00};
				3'd3: img_h[7:0] = b;
				3'd4: assembly = {16'h0, b};
				3'd5: begin
					pal_full = {assembly[7:0], b};
					pal_cnt  = (pal_full == 16'd0 || pal_full > PAL_DEPTH_DEF) ?
						9'd0 : pal_full[8:0];
					assembly = 24'd0;
				end
				default: ;
				endcase
				if (hdr_count == 3'd7) begin
					if (img_w == 16'd0 || img_h == 16'd0 || pal_cnt == 9'd0) begin
						dec_phase = DEC_BAD_HDR;
					end else begin
						dec_phase = DEC_PALETTE;
						fill      = 9'd0;
						byte_idx  = 2'd0;
						assembly  = 24'd0;
					end
				end
				hdr_count = hdr_count + 3'd1;
			end
			DEC_PALETTE: begin
				if (byte_idx < 2'd3) begin
					assembly = {assembly[15:0], b};
					byte_idx = byte_idx + 2'd1;
				end else begin
					palette[fill[7:0]] = {assembly, b};
					assembly = 24'd0;
					byte_idx = 2'd0;
					fill     = fill + 9'd1;
					if (fill >= pal_cnt) begin
						dec_phase = DEC_PIXELS;
						col_n     = 16'd0;
						row_n     = 16'd0;
					end
				end
			end
			DEC_PIXELS: begin
				// an index at or past the palette count maps to zero
				r.pixel_word = ({1'b0, b} < pal_cnt) ? palette[b] : 32'h0;
				r.col        = col_n;
				r.line       = row_n;
				r.status     = ST_PIXEL;
				r.final_res  = 1'b0;
				expected_results.push_back(r);
				col_n = col_n + 16'd1;
				if (col_n >= img_w) begin
					col_n = 16'd0;
					row_n = row_n + 16'd1;
					if (row_n >= img_h)
						dec_phase = DEC_TAIL;
				end
			end
			default: ;
			endcase

			if (last) begin
				r.pixel_word = 32'h0;
				r.col        = 16'd0;
				r.line       = 16'd0;
				r.final_res  = 1'b1;
				if (dec_phase == DEC_TAIL)
					r.status = ST_DONE;
				else if (dec_phase == DEC_BAD_HDR)
					r.status = ST_BAD;
				else
					r.status = ST_TRUNC;
				expected_results.push_back(r);
				restart_blob();
			end
		endfunction

		function void check_result(pix_result_t got);
			pix_result_t want;
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h", $time, got);
				fail_count++;
				return;
			end
			want = expected_results.pop_front();
			if (got.pixel_word !== want.pixel_word) begin
				$display("%0t pixel_word mismatch: expected %h actual %h",
					$time, want.pixel_word, got.pixel_word);
				fail_count++;
			end
			if (got.col !== want.col) begin
				$display("%0t col mismatch: expected %0d actual %0d", $time, want.col, got.col);
				fail_count++;
			end
			if (got.line !== want.line) begin
				$display("%0t line mismatch: expected %0d actual %0d",
					$time, want.line, got.line);
				fail_count++;
			end
			if (got.status !== want.status) begin
				$display("%0t status mismatch: expected %0d actual %0d",
					$time, want.status, got.status);
				fail_count++;
			end
			if (got.final_res !== want.final_res) begin
				$display("%0t final_res mismatch: expected %b actual %b",
					$time, want.final_res, got.final_res);
				fail_count++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        end_of_blob;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] pixel_word;
	logic [15:0] col;
	logic [15:0] line;
	logic [1:0]  status;
	logic        final_res;

	pixel_scoreboard sb;
	logic [7:0]      blob_q[$];
	int              send_idle_pct;
	int              recv_stall_pct;
	int              bytes_sent;
	int              cycle_count;

	palette_image_stream_decoder_core #(
		.PALETTE_DEPTH(PAL_DEPTH_DEF)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.end_of_blob(end_of_blob),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_word (pixel_word),
		.col        (col),
		.line       (line),
		.status     (status),
		.final_res  (final_res)
	);

	// free-running clock, 8 ns period
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: random stall per cycle at the current stall rate
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// monitor: sample mid-cycle, a result taken at the next rising edge is checked
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{pixel_word, col, line, status, final_res});
	end

	// watchdog, generous against the slowest legal run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
		IDLE_NONE: begin
			send_idle_pct  = 0;
			recv_stall_pct = 0;
		end
		IDLE_SENDER: begin
			send_idle_pct  = 75;
			recv_stall_pct = 0;
		end
		IDLE_RECEIVER: begin
			send_idle_pct  = 0;
			recv_stall_pct = 75;
		end
		default: begin
			send_idle_pct  = 35;
			recv_stall_pct = 35;
		end
		endcase
	endtask

	// offer one byte request and hold it until the block takes it; called at a rising edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		bit taken;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		in_byte     <= b;
		end_of_blob <= last;
		// stall is settled by mid-cycle, so the falling edge tells whether the next edge takes it
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		sb.note_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_blob();
		for (int i = 0; i < blob_q.size(); i++)
			send_byte(blob_q[i], i == blob_q.size() - 1);
	endtask

	task automatic add_header(input logic [15:0] w, input logic [15:0] h, input logic [15:0] pc);
		blob_q.push_back(w[15:8]);
		blob_q.push_back(w[7:0]);
		blob_q.push_back(h[15:8]);
		blob_q.push_back(h[7:0]);
		blob_q.push_back(pc[15:8]);
		blob_q.push_back(pc[7:0]);
		// two bytes the decoder skips
		blob_q.push_back(8'($urandom_range(255)));
		blob_q.push_back(8'($urandom_range(255)));
	endtask

	task automatic add_word(input logic [31:0] w);
		blob_q.push_back(w[31:24]);
		blob_q.push_back(w[23:16]);
		blob_q.push_back(w[15:8]);
		blob_q.push_back(w[7:0]);
	endtask

	// fill blob_q with one blob of the given kind, random content throughout
	task automatic build_random_blob(input blob_kind_t kind);
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] pc;
		logic [31:0] colour;
		logic [7:0]  idx;
		int          pix_n;
		int          tail_n;
		int          cut;
		int          hdr_pal_len;
		blob_q.delete();
		w      = 16'($urandom_range(6, 1));
		h      = 16'($urandom_range(4, 1));
		pc     = 16'($urandom_range(6, 1));
		tail_n = ($urandom_range(1) == 0) ? 0 : $urandom_range(3, 1);
		case (kind)
		BLOB_EXTREME: begin
			// widest image and fullest palette, cut short after 40 pixels
			w      = 16'hFFFF;
			h      = 16'hFFFF;
			pc     = 16'(PAL_DEPTH_DEF);
			tail_n = 0;
		end
		BLOB_BAD_HDR: begin
			case ($urandom_range(3))
			0: w = 16'd0;
			1: h = 16'd0;
			2: pc = 16'd0;
			default: pc = 16'($urandom_range(16'hFFFF, PAL_DEPTH_DEF + 1));
			endcase
			tail_n = $urandom_range(10);
		end
		BLOB_TRUNC_PIX: begin
			if (w * h < 2)
				w = 16'd2;
		end
		default: ;
		endcase
		pix_n = (kind == BLOB_EXTREME) ? 40 : w * h;

		if (kind == BLOB_NOISE) begin
			repeat ($urandom_range(30, 1)) blob_q.push_back(8'($urandom_range(255)));
		end else begin
			add_header(w, h, pc);
			if (w != 16'd0 && h != 16'd0 && pc != 16'd0 && pc <= PAL_DEPTH_DEF) begin
				repeat (pc) begin
					case ($urandom_range(3))
					0: colour = 32'h0000_0000;
					1: colour = 32'hFFFF_FFFF;
					default: colour = $urandom;
					endcase
					add_word(colour);
				end
				for (int i = 0; i < pix_n; i++) begin
					case ($urandom_range(7))
					0: idx = 8'($urandom_range(255));
					1: idx = pc[7:0];	// first index past the palette, wraps to 0 for a full palette
					default: idx = 8'($urandom_range(pc - 1));
					endcase
					if (kind == BLOB_EXTREME && i == 0)
						idx = 8'hFF;
					blob_q.push_back(idx);
				end
			end
			repeat (tail_n) blob_q.push_back(8'($urandom_range(255)));
		end

		hdr_pal_len = 8 + 4 * pc;
		case (kind)
		BLOB_TRUNC_HDR: cut = $urandom_range(7, 1);
		BLOB_TRUNC_PAL: cut = $urandom_range(hdr_pal_len, 9);
		BLOB_TRUNC_PIX: cut = $urandom_range(hdr_pal_len + pix_n - 1, hdr_pal_len + 1);
		default:        cut = blob_q.size();
		endcase
		while (blob_q.size() > cut)
			void'(blob_q.pop_back());
	endtask

	initial begin
		int         blob_no;
		int         pick;
		blob_kind_t kind;

		sb = new;
		bytes_sent     = 0;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		in_byte       <= 8'h00;
		end_of_blob   <= 1'b0;
		set_idling(IDLE_NONE);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: a blob of one byte ends inside the header
		blob_q = '{8'hFF};
		send_blob();

		// directed: zero width, blob closes on the last header byte
		blob_q.delete();
		add_header(16'd0, 16'd1, 16'd1);
		send_blob();

		// directed: in-range and out-of-range index, last pixel also closes the blob
		blob_q.delete();
		add_header(16'd2, 16'd1, 16'd1);
		add_word(32'hFFFF_FFFF);
		blob_q.push_back(8'h00);
		blob_q.push_back(8'hFF);
		send_blob();

		// random: every kind once in turn, then a mix weighted to well-formed blobs
		blob_no    = 0;
		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES || blob_no <= BLOB_EXTREME) begin
			if (blob_no <= BLOB_EXTREME) begin
				kind = blob_kind_t'(blob_no);
			end else begin
				pick = $urandom_range(99);
				if (pick < 55)
					kind = BLOB_GOOD;
				else if (pick < 63)
					kind = BLOB_TRUNC_PAL;
				else if (pick < 73)
					kind = BLOB_TRUNC_PIX;
				else if (pick < 80)
					kind = BLOB_TRUNC_HDR;
				else if (pick < 92)
					kind = BLOB_BAD_HDR;
				else
					kind = BLOB_NOISE;
			end
			set_idling(idle_mode_t'(blob_no % 4));
			build_random_blob(kind);
			send_blob();
			blob_no++;
		end

		// drain: nothing more offered, let outstanding results arrive
		in_valid <= 1'b0;
		set_idling(IDLE_NONE);
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.expected_results.size() != 0) begin
			$display("%0t %0d expected results never arrived", $time,
				sb.expected_results.size());
			sb.fail_count++;
		end
		if (sb.fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== palette_image_stream_decoder_core.f =====
rtl/core/pisd_pkg.sv
rtl/core/pisd_ram.sv
rtl/core/palette_image_stream_decoder_core.sv
rtl/core/pisd_checker.sv
dv/palette_image_stream_decoder_core_tb.sv
